FILE: rtl/gwps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwps_pkg
// Shared constants, codes and types for the grid word path search unit.
// ----------------------------------------------------------------------------
package gwps_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int MAX_WORD = 16;

  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;
  localparam int CELL_W  = ROW_W + COL_W;
  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int WIDX_W  = 4;
  localparam int SYM_W   = 8;
  localparam int DIM_W   = 4;
  localparam int LEN_W   = 5;
  localparam int DEPTH_W = 5;
  localparam int DIR_W   = 3;
  localparam int CMD_W   = 2;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 5;

  localparam logic [CMD_W-1:0] CMD_GRID   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WORD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_LEN  = 2'd2;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [LEN_W-1:0] len;
  } gwps_cfg_t;

  typedef struct packed {
    logic              start;
    logic [CMD_W-1:0]  cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [WIDX_W-1:0] widx;
    logic [SYM_W-1:0]  symbol;
  } gwps_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic found;
  } gwps_sts_t;

  typedef struct packed {
    logic              ok;
    logic [CELL_W-1:0] pos;
  } gwps_nbr_t;

endpackage

FILE: rtl/gwps_nbr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwps_nbr
// Neighbour step unit: next cell in a given direction, with bounds check.
// ----------------------------------------------------------------------------
module gwps_nbr
  import gwps_pkg::*;
(
  input  logic [CELL_W-1:0] cur,
  input  logic [1:0]        dir,
  input  logic [DIM_W-1:0]  rows,
  input  logic [DIM_W-1:0]  cols,
  output gwps_nbr_t         nbr
);

  logic [ROW_W-1:0] tr;
  logic [COL_W-1:0] tc;
  logic [DIM_W-1:0] tr_inc;
  logic [DIM_W-1:0] tc_inc;

  assign tr     = cur[CELL_W-1:COL_W];
  assign tc     = cur[COL_W-1:0];
  assign tr_inc = DIM_W'(tr) + DIM_W'(1);
  assign tc_inc = DIM_W'(tc) + DIM_W'(1);

  always_comb begin
    nbr.ok  = 1'b0;
    nbr.pos = cur;
    unique case (dir)
      DIR_DOWN: begin
        nbr.ok  = (tr_inc < rows);
        nbr.pos = {ROW_W'(tr_inc), tc};
      end
      DIR_UP: begin
        nbr.ok  = (tr != '0);
        nbr.pos = {tr - ROW_W'(1), tc};
      end
      DIR_LEFT: begin
        nbr.ok  = (tc != '0);
        nbr.pos = {tr, tc - COL_W'(1)};
      end
      DIR_RIGHT: begin
        nbr.ok  = (tc_inc < cols);
        nbr.pos = {tr, COL_W'(tc_inc)};
      end
      default: begin
        nbr.ok = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/gwps_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwps_engine
// Grid and word stores plus the backtracking search sequencer.
// ----------------------------------------------------------------------------
module gwps_engine
  import gwps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  gwps_cfg_t cfg,
  input  gwps_req_t req,
  input  logic      res_free,
  output gwps_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ST_RD  = 3'd1;
  localparam logic [2:0] S_ST_CMP = 3'd2;
  localparam logic [2:0] S_TOP    = 3'd3;
  localparam logic [2:0] S_NB_CMP = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [SYM_W-1:0]  grid_mem [CELLS];
  logic [SYM_W-1:0]  grid_q_r;
  logic [CELL_W-1:0] rd_addr;

  logic [SYM_W-1:0]  word_r [MAX_WORD];
  logic [CELL_W-1:0] stk_cell_r [MAX_WORD];
  logic [DIR_W-1:0]  stk_dir_r  [MAX_WORD];

  logic [2:0]         state_r, state_nxt;
  logic [ROW_W-1:0]   sr_r, sr_nxt;
  logic [COL_W-1:0]   sc_r, sc_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [CELL_W-1:0]  ncell_r, ncell_nxt;
  logic               found_r, found_nxt;

  logic              stk_we;
  logic [WIDX_W-1:0] stk_waddr;
  logic [CELL_W-1:0] stk_wcell;
  logic [DIR_W-1:0]  stk_wdir;

  logic [DIM_W-1:0]  rows_s, cols_s;
  logic [LEN_W-1:0]  len_s;
  logic [WIDX_W-1:0] top_idx;
  logic [CELL_W-1:0] top_cell;
  logic [DIR_W-1:0]  top_dir;
  logic [CELL_W-1:0] st_cell;
  logic              col_more, row_more;
  logic              nb_seen;
  gwps_nbr_t         nbr;

  assign rows_s   = (cfg.rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg.rows;
  assign cols_s   = (cfg.cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg.cols;
  assign len_s    = (cfg.len > LEN_W'(MAX_WORD)) ? LEN_W'(MAX_WORD) : cfg.len;
  assign top_idx  = depth_r[WIDX_W-1:0] - WIDX_W'(1);
  assign top_cell = stk_cell_r[top_idx];
  assign top_dir  = stk_dir_r[top_idx];
  assign st_cell  = {sr_r, sc_r};
  assign col_more = (DIM_W'(sc_r) + DIM_W'(1)) < cols_s;
  assign row_more = (DIM_W'(sr_r) + DIM_W'(1)) < rows_s;

  gwps_nbr u_nbr (
    .cur  (top_cell),
    .dir  (top_dir[1:0]),
    .rows (rows_s),
    .cols (cols_s),
    .nbr  (nbr)
  );

  // visited cells are exactly the cells on the live part of the path stack
  always_comb begin
    nb_seen = 1'b0;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (DEPTH_W'(i) < depth_r && stk_cell_r[i] == nbr.pos) begin
        nb_seen = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    sr_nxt    = sr_r;
    sc_nxt    = sc_r;
    depth_nxt = depth_r;
    ncell_nxt = ncell_r;
    found_nxt = found_r;
    stk_we    = 1'b0;
    stk_waddr = top_idx;
    stk_wcell = top_cell;
    stk_wdir  = top_dir + DIR_W'(1);
    rd_addr   = st_cell;

    unique case (state_r)
      S_IDLE: begin
        if (req.start && req.cmd == CMD_SEARCH) begin
          sr_nxt = '0;
          sc_nxt = '0;
          if (rows_s == '0 || cols_s == '0 || len_s == '0) begin
            found_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ST_RD;
          end
        end
      end
      S_ST_RD: begin
        rd_addr   = st_cell;
        state_nxt = S_ST_CMP;
      end
      S_ST_CMP: begin
        if (grid_q_r == word_r[0]) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wcell = st_cell;
          stk_wdir  = '0;
          depth_nxt = DEPTH_W'(1);
          state_nxt = S_TOP;
        end else if (col_more) begin
          sc_nxt    = sc_r + COL_W'(1);
          state_nxt = S_ST_RD;
        end else if (row_more) begin
          sr_nxt    = sr_r + ROW_W'(1);
          sc_nxt    = '0;
          state_nxt = S_ST_RD;
        end else begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_TOP: begin
        if (DEPTH_W'(len_s) <= depth_r) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (top_dir[DIR_W-1]) begin
          // all four directions tried: backtrack
          depth_nxt = depth_r - DEPTH_W'(1);
          if (depth_r == DEPTH_W'(1)) begin
            if (col_more) begin
              sc_nxt    = sc_r + COL_W'(1);
              state_nxt = S_ST_RD;
            end else if (row_more) begin
              sr_nxt    = sr_r + ROW_W'(1);
              sc_nxt    = '0;
              state_nxt = S_ST_RD;
            end else begin
              found_nxt = 1'b0;
              state_nxt = S_DONE;
            end
          end
        end else begin
          stk_we = 1'b1;
          if (nbr.ok && !nb_seen) begin
            rd_addr   = nbr.pos;
            ncell_nxt = nbr.pos;
            state_nxt = S_NB_CMP;
          end
        end
      end
      S_NB_CMP: begin
        if (grid_q_r == word_r[depth_r[WIDX_W-1:0]]) begin
          stk_we    = 1'b1;
          stk_waddr = depth_r[WIDX_W-1:0];
          stk_wcell = ncell_r;
          stk_wdir  = '0;
          depth_nxt = depth_r + DEPTH_W'(1);
        end
        state_nxt = S_TOP;
      end
      S_DONE: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sr_r    <= '0;
      sc_r    <= '0;
      depth_r <= '0;
      ncell_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sr_r    <= sr_nxt;
      sc_r    <= sc_nxt;
      depth_r <= depth_nxt;
      ncell_r <= ncell_nxt;
      found_r <= found_nxt;
    end
  end

  // grid memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && req.start && req.cmd == CMD_GRID) begin
      grid_mem[{req.row, req.col}] <= req.symbol;
    end
    grid_q_r <= grid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && req.start && req.cmd == CMD_WORD) begin
      word_r[req.widx] <= req.symbol;
    end
    if (stk_we) begin
      stk_cell_r[stk_waddr] <= stk_wcell;
      stk_dir_r[stk_waddr]  <= stk_wdir;
    end
  end

  assign sts.idle  = (state_r == S_IDLE);
  assign sts.done  = (state_r == S_DONE) && res_free;
  assign sts.found = found_r;

endmodule

FILE: rtl/grid_word_path_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_word_path_search_unit
// Grid and word loader with a backtracking word path search.
// ----------------------------------------------------------------------------
//  channel  dir  words                            notes
//  in_      in   command, row, col, index, symbol load or search
//  out_     out  found                            one word per search
//  cfg_     in   rows, cols, word length          write only
//
//  Load commands leave the unit ready for the next input. A search reads and
//  compares each start cell tried, takes stack steps, reads the grid for each
//  free neighbour, and then hands the result over; the grid RAM read port and
//  the single neighbour unit set this pace. Input is held off while a search
//  runs. Reset is synchronous, active low; grid and word contents survive
//  only as written. A stalled result holds the search in its final state.
// ----------------------------------------------------------------------------
module grid_word_path_search_unit
  import gwps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFGD_W-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // command, cell_row, cell_col, word_index, symbol
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata   // found
);

  logic [DIM_W-1:0] rows_r, cols_r;
  logic [LEN_W-1:0] len_r;
  logic             out_tvalid_r;
  logic             out_found_r;
  logic             res_free;
  gwps_cfg_t        cfg;
  gwps_req_t        req;
  gwps_sts_t        sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(MAX_ROWS);
      cols_r <= DIM_W'(MAX_COLS);
      len_r  <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: rows_r <= cfg_wdata[DIM_W-1:0];
        CFG_COLS: cols_r <= cfg_wdata[DIM_W-1:0];
        CFG_LEN:  len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.rows = rows_r;
  assign cfg.cols = cols_r;
  assign cfg.len  = len_r;

  assign in_tready  = sts.idle;
  assign req.start  = in_tvalid && in_tready;
  assign req.cmd    = in_tdata[1:0];
  assign req.row    = in_tdata[4:2];
  assign req.col    = in_tdata[7:5];
  assign req.widx   = in_tdata[11:8];
  assign req.symbol = in_tdata[19:12];

  assign res_free = !out_tvalid_r || out_tready;

  gwps_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .req      (req),
    .res_free (res_free),
    .sts      (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (sts.done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      out_found_r <= sts.found;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_found_r};

  a_load_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[1:0] != CMD_SEARCH) |=> in_tready)
    else $error("load command left the unit busy");

  a_search_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[1:0] == CMD_SEARCH) |=> !in_tready)
    else $error("search accepted without going busy");

  a_done_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (!out_tvalid || out_tready))
    else $error("result overwrote a pending word");

  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !in_tready)
    else $error("search finished while idle");

endmodule

FILE: sim/tb_grid_word_path_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_word_path_search_unit
// Loads grids and words, runs searches under many grid and word shapes and
// checks every found word against a backtracking predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_grid_word_path_search_unit
  import gwps_pkg::*;
();

  localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;
  localparam int SEARCH_BUDGET = 2000;
  localparam int IDLE_SETTLE   = 10;
  localparam int ITEM_TARGET   = 1650;

  typedef struct {
    logic [23:0] tdata;
    bit          is_search;
    bit          found;
  } search_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFGD_W-1:0] cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;   // command, cell_row, cell_col, word_index, symbol
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // found

  search_cmd_t cmd_fifo[$];
  bit          found_exp_q[$];
  search_cmd_t head;
  int          feed_gap = 0;
  int          rdy_hold = 0;
  bit          calm = 1'b0;
  int          mismatches = 0;
  int          n_items = 0;

  logic [SYM_W-1:0] grid_sh[CELLS];
  logic [SYM_W-1:0] word_sh[MAX_WORD];
  logic [DIM_W-1:0] rows_sh = 4'd8;
  logic [DIM_W-1:0] cols_sh = 4'd8;
  logic [LEN_W-1:0] len_sh  = 5'd1;
  logic [7:0]       alpha[5];
  int               alpha_n = 3;

  grid_word_path_search_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int u;
    u = $urandom_range(0, 99);
    if (u < 65) return 0;
    if (u < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_sym();
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  // Depth-first walk, directions down, up, left, right; cost tracks cycles.
  function automatic bit trace_word(output int cost);
    int  rows, cols, len, s, d, k, tr, tc, nr, nc, n;
    bit  seen[CELLS];
    int  cell_stk[MAX_WORD];
    int  dir_stk[MAX_WORD];
    bit  ok;
    rows = (rows_sh > MAX_ROWS) ? MAX_ROWS : rows_sh;
    cols = (cols_sh > MAX_COLS) ? MAX_COLS : cols_sh;
    len  = (len_sh > MAX_WORD) ? MAX_WORD : len_sh;
    cost = 2;
    if (rows == 0 || cols == 0 || len == 0) return 1'b0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        s = r * MAX_COLS + c;
        cost += 2;
        if (grid_sh[s] != word_sh[0]) continue;
        foreach (seen[i]) seen[i] = 1'b0;
        seen[s] = 1'b1;
        cell_stk[0] = s;
        dir_stk[0] = 0;
        d = 1;
        while (d > 0) begin
          if (d >= len) return 1'b1;
          cost += 1;
          if (dir_stk[d-1] >= 4) begin
            seen[cell_stk[d-1]] = 1'b0;
            d--;
            continue;
          end
          k = dir_stk[d-1];
          dir_stk[d-1]++;
          tr = cell_stk[d-1] / MAX_COLS;
          tc = cell_stk[d-1] % MAX_COLS;
          nr = tr;
          nc = tc;
          ok = 1'b0;
          if (k == DIR_DOWN && tr + 1 < rows) begin
            nr = tr + 1;
            ok = 1'b1;
          end else if (k == DIR_UP && tr > 0) begin
            nr = tr - 1;
            ok = 1'b1;
          end else if (k == DIR_LEFT && tc > 0) begin
            nc = tc - 1;
            ok = 1'b1;
          end else if (k == DIR_RIGHT && tc + 1 < cols) begin
            nc = tc + 1;
            ok = 1'b1;
          end
          if (!ok) continue;
          cost += 1;
          n = nr * MAX_COLS + nc;
          if (seen[n] || grid_sh[n] != word_sh[d]) continue;
          seen[n] = 1'b1;
          cell_stk[d] = n;
          dir_stk[d] = 0;
          d++;
        end
      end
    end
    return 1'b0;
  endfunction

  // Searches whose walk would run past the budget are dropped.
  task automatic post(input logic [CMD_W-1:0] cmd, input int row, input int col,
                      input int widx, input int sym);
    search_cmd_t item;
    int          cost;
    item.tdata     = {4'b0, sym[7:0], widx[3:0], col[2:0], row[2:0], cmd};
    item.is_search = (cmd == CMD_SEARCH);
    item.found     = 1'b0;
    case (cmd)
      CMD_GRID: grid_sh[row * MAX_COLS + col] = sym[7:0];
      CMD_WORD: word_sh[widx] = sym[7:0];
      CMD_SEARCH: begin
        item.found = trace_word(cost);
        if (cost > SEARCH_BUDGET) return;
      end
      default: ;
    endcase
    cmd_fifo.push_back(item);
    if (cmd != CMD_IDLE) n_items++;
  endtask

  task automatic post_grid(input int row, input int col, input int sym);
    post(CMD_GRID, row, col, $urandom_range(0, 15), sym);
  endtask

  task automatic post_char(input int widx, input int sym);
    post(CMD_WORD, $urandom_range(0, 7), $urandom_range(0, 7), widx, sym);
  endtask

  task automatic post_search();
    post(CMD_SEARCH, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 15),
         $urandom_range(0, 255));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_fifo.size() != 0 || in_tvalid || found_exp_q.size() != 0);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFGD_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_ROWS: rows_sh = val[3:0];
      CFG_COLS: cols_sh = val[3:0];
      CFG_LEN:  len_sh  = val;
      default: ;
    endcase
  endtask

  task automatic set_shape(input int rows, input int cols, input int len);
    write_reg(CFG_ROWS, rows[4:0]);
    write_reg(CFG_COLS, cols[4:0]);
    write_reg(CFG_LEN, len[4:0]);
  endtask

  task automatic new_alphabet();
    alpha_n = $urandom_range(3, 5);
    foreach (alpha[i]) alpha[i] = $urandom_range(1, 254);
  endtask

  // Lays the word along a random self-avoiding walk inside the live area.
  task automatic plant_word(input int rows, input int cols, input int len);
    bit          used[CELLS];
    int          cand[4];
    int          nc, cur, r, c, i;
    logic [7:0]  sym;
    cur = $urandom_range(0, rows - 1) * MAX_COLS + $urandom_range(0, cols - 1);
    for (i = 0; i < len; i++) begin
      sym = pick_sym();
      post_grid(cur / MAX_COLS, cur % MAX_COLS, sym);
      post_char(i, sym);
      used[cur] = 1'b1;
      r = cur / MAX_COLS;
      c = cur % MAX_COLS;
      nc = 0;
      if (r + 1 < rows && !used[cur + MAX_COLS]) cand[nc++] = cur + MAX_COLS;
      if (r > 0 && !used[cur - MAX_COLS])        cand[nc++] = cur - MAX_COLS;
      if (c > 0 && !used[cur - 1])               cand[nc++] = cur - 1;
      if (c + 1 < cols && !used[cur + 1])        cand[nc++] = cur + 1;
      if (nc == 0) break;
      cur = cand[$urandom_range(0, nc - 1)];
    end
    for (i = i + 1; i < len; i++) post_char(i, pick_sym());
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (mismatches < 10)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      feed_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready && head.is_search) found_exp_q.push_back(head.found);
      if (!in_tvalid || in_tready) begin
        if (feed_gap > 0 || cmd_fifo.size() == 0) begin
          in_tvalid <= 1'b0;
          if (feed_gap > 0) feed_gap <= feed_gap - 1;
        end else begin
          head = cmd_fifo.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= head.tdata;
          feed_gap  <= calm ? 0 : pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rdy_hold   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (found_exp_q.size() == 0)
          flag_mismatch("found word with no search pending", 8'hxx, out_tdata);
        else if (out_tdata !== {7'b0, found_exp_q[0]})
          flag_mismatch("found", {7'b0, found_exp_q.pop_front()}, out_tdata);
        else
          void'(found_exp_q.pop_front());
      end
      if (rdy_hold > 0) begin
        out_tready <= 1'b0;
        rdy_hold   <= rdy_hold - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        rdy_hold   <= pick_gap();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int ph, er, ec, el, rw;
    new_alphabet();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < CELLS; i++) post_grid(i / MAX_COLS, i % MAX_COLS, pick_sym());
    for (int i = 0; i < MAX_WORD; i++) post_char(i, pick_sym());
    wait_drained();

    // field extremes, single-character word under reset shape
    post_grid(0, 0, 8'h00);
    post_grid(7, 7, 8'hFF);
    post_char(0, 8'hFF);
    post_char(15, 8'h00);
    post_search();
    post(CMD_IDLE, 7, 7, 15, 8'hFF);
    wait_drained();

    // a path may not revisit a cell; repeat search sees a cleared map
    set_shape(1, 2, 3);
    post_grid(0, 0, alpha[0]);
    post_grid(0, 1, 8'hFF);
    post_char(0, alpha[0]);
    post_char(1, 8'hFF);
    post_char(2, alpha[0]);
    post_search();
    post_search();
    wait_drained();
    write_reg(CFG_LEN, 5'd2);
    post_search();
    wait_drained();

    // zero-sized shapes
    write_reg(CFG_ROWS, 5'd0);
    post_search();
    wait_drained();
    set_shape(1, 0, 2);
    post_search();
    wait_drained();
    set_shape(1, 2, 0);
    post_search();
    wait_drained();

    // oversized and masked register values saturate
    set_shape(24, 9, 31);
    plant_word(MAX_ROWS, MAX_COLS, MAX_WORD);
    post_search();
    wait_drained();

    // end of a row is not adjacent to the start of the next
    set_shape(8, 8, 2);
    post_grid(0, 0, alpha[1]);
    post_grid(0, 7, 8'h00);
    post_grid(1, 0, 8'hFF);
    post_char(0, 8'h00);
    post_char(1, 8'hFF);
    post_search();
    post_grid(0, 0, 8'h00);
    post_search();

    for (ph = 0; n_items < ITEM_TARGET; ph++) begin
      wait_drained();
      case (ph)
        0: begin er = 8; ec = 8; el = 16; end
        1: begin er = 1; ec = 1; el = 1; end
        2: begin er = 1; ec = 8; el = 5; end
        3: begin er = 8; ec = 1; el = 5; end
        default: begin
          er = $urandom_range(1, 8);
          ec = $urandom_range(1, 8);
          el = $urandom_range(1, (er * ec < MAX_WORD) ? er * ec + 1 : MAX_WORD);
        end
      endcase
      rw = ($urandom_range(0, 11) == 0 && er == 8) ? $urandom_range(9, 15) : er;
      set_shape(rw, ec, el);
      new_alphabet();
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 10)) begin
        repeat ($urandom_range(0, 5))
          post_grid($urandom_range(0, 7), $urandom_range(0, 7), pick_sym());
        if ($urandom_range(0, 99) < 60) begin
          plant_word(er, ec, el);
          if ($urandom_range(0, 4) == 0)
            post_char($urandom_range(0, el - 1), $urandom_range(0, 255));
        end else begin
          repeat ($urandom_range(1, 4)) post_char($urandom_range(0, 15), pick_sym());
        end
        if ($urandom_range(0, 19) == 0)
          post(CMD_IDLE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 15),
               $urandom_range(0, 255));
        post_search();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && found_exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
